@@ rtl/llca_pkg.sv @@
// ----------------------------------------------------------------------------
// llca_pkg - shared types for the least-loaded chunk assigner
// Request and result payloads, queued row tasks and register indexes.
// ----------------------------------------------------------------------------
package llca_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = CFG_IDX_W'(1);

  localparam logic [4:0]  NODE_COUNT_RST  = 5'd16;
  localparam logic [15:0] CHUNK_LIMIT_RST = 16'd1024;

  typedef struct packed {
    logic [19:0] row_id;
    logic [15:0] row_length;
    logic [31:0] row_start;
  } row_in_t;

  typedef struct packed {
    logic [19:0] chunk_row;
    logic [15:0] chunk_length;
    logic [31:0] chunk_start;
    logic [3:0]  node;
    logic [31:0] new_load;
    logic        last_chunk;
  } chunk_out_t;

  // Row request with its effective chunk limit already worked out
  typedef struct packed {
    row_in_t     row;
    logic [15:0] lim;
  } task_t;

endpackage

@@ rtl/llca_ram.sv @@
// ----------------------------------------------------------------------------
// llca_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/llca_fifo.sv @@
// ----------------------------------------------------------------------------
// llca_fifo - two-entry queue
// Flip-flop queue used between the front, the back and the result side.
// ----------------------------------------------------------------------------
module llca_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] ent_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/llca_front.sv @@
// ----------------------------------------------------------------------------
// llca_front - request intake
// Accepts row requests, attaches the effective chunk limit and queues them;
// also works out the number of active nodes.
// ----------------------------------------------------------------------------
module llca_front import llca_pkg::*; #(
  parameter int MAX_NODES = 16,
  localparam int NW = $clog2(MAX_NODES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  row_in_t       in_i,
  input  logic [4:0]    node_count_i,
  input  logic [15:0]   chunk_limit_i,
  output task_t         task_o,
  output logic          task_valid_o,
  input  logic          task_pop_i,
  output logic [NW-1:0] n_o
);

  task_t       wtask;
  logic [$bits(task_t)-1:0] rdata;
  logic        q_empty;

  always_comb begin
    wtask.row = in_i;
    wtask.lim = (chunk_limit_i == 16'd0) ? 16'd1 : chunk_limit_i;
  end

  // Zero acts as one node, anything above the node array clamps to its size
  always_comb begin
    if (node_count_i == 5'd0) begin
      n_o = NW'(1);
    end else if (32'(node_count_i) > 32'(MAX_NODES)) begin
      n_o = NW'(MAX_NODES);
    end else begin
      n_o = NW'(node_count_i);
    end
  end

  llca_fifo #(.W($bits(task_t))) u_taskq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wtask),
    .full_o  (full),
    .pop_i   (task_pop_i),
    .data_o  (rdata),
    .empty_o (q_empty)
  );

  assign task_o       = task_t'(rdata);
  assign task_valid_o = !q_empty;

endmodule

@@ rtl/llca_back.sv @@
// ----------------------------------------------------------------------------
// llca_back - chunk engine
// Cuts each row into chunks, scans the node loads for the smallest one and
// adds the chunk to it with saturation.
// ----------------------------------------------------------------------------
module llca_back import llca_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_CHUNKS = 64,
  localparam int NW = $clog2(MAX_NODES + 1),
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int KW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] n_i,
  input  task_t         task_i,
  input  logic          task_valid_i,
  output logic          task_pop_o,
  output chunk_out_t    res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_e;

  state_e          state_q;
  logic [19:0]     id_q;
  logic [31:0]     start_q;
  logic [15:0]     rem_q;
  logic [15:0]     lim_q;
  logic [KW-1:0]   k_q;
  logic [NW-1:0]   j_q;
  logic            rpend_q;
  logic [IW-1:0]   ridx_q;
  logic            rvld_q;
  logic [IW-1:0]   best_q;
  logic [31:0]     best_load_q;
  logic [MAX_NODES-1:0] vld_q;

  logic            issue;
  logic [31:0]     rdata;
  logic [31:0]     cur;
  logic            last;
  logic [15:0]     clen;
  logic [32:0]     sum;
  logic [31:0]     new_load;
  logic            upd_go;

  assign issue = (state_q == ST_SCAN) && (j_q < n_i);
  // Never-written loads read as zero
  assign cur   = rvld_q ? rdata : 32'd0;

  assign last     = (k_q == KW'(MAX_CHUNKS - 1)) || (rem_q <= lim_q);
  assign clen     = last ? rem_q : lim_q;
  assign sum      = {1'b0, best_load_q} + {17'd0, clen};
  assign new_load = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign upd_go   = (state_q == ST_UPD) && !res_full_i;

  assign task_pop_o = (state_q == ST_IDLE) && task_valid_i;
  assign res_push_o = upd_go;

  always_comb begin
    res_o.chunk_row    = id_q;
    res_o.chunk_length = clen;
    res_o.chunk_start  = start_q;
    res_o.node         = 4'(best_q);
    res_o.new_load     = new_load;
    res_o.last_chunk   = last;
  end

  llca_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_loads (
    .clk_i   (clk_i),
    .we_i    (upd_go),
    .waddr_i (best_q),
    .wdata_i (new_load),
    .raddr_i (j_q[IW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      id_q        <= '0;
      start_q     <= '0;
      rem_q       <= '0;
      lim_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      rpend_q     <= 1'b0;
      ridx_q      <= '0;
      rvld_q      <= 1'b0;
      best_q      <= '0;
      best_load_q <= '0;
      vld_q       <= '0;
    end else begin
      rpend_q <= issue;
      ridx_q  <= j_q[IW-1:0];
      rvld_q  <= vld_q[j_q[IW-1:0]];
      unique case (state_q)
        ST_IDLE: begin
          if (task_valid_i) begin
            id_q    <= task_i.row.row_id;
            start_q <= task_i.row.row_start;
            rem_q   <= task_i.row.row_length;
            lim_q   <= task_i.lim;
            k_q     <= '0;
            j_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            j_q <= j_q + NW'(1);
          end
          if (rpend_q) begin
            // Strict compare keeps the lowest index on ties
            if (ridx_q == '0 || cur < best_load_q) begin
              best_q      <= ridx_q;
              best_load_q <= cur;
            end
            if (ridx_q == IW'(n_i - NW'(1))) begin
              state_q <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          if (!res_full_i) begin
            vld_q[best_q] <= 1'b1;
            start_q       <= start_q + {16'd0, clen};
            rem_q         <= rem_q - clen;
            k_q           <= k_q + KW'(1);
            j_q           <= '0;
            state_q       <= last ? ST_IDLE : ST_SCAN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/least_loaded_chunk_assigner.sv @@
// ----------------------------------------------------------------------------
// least_loaded_chunk_assigner - greedy least-loaded chunk assignment
// Cuts sparse-matrix rows into chunks and hands each to the lightest node.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   push / full          in_i  (row_in_t)
//  result    pop / empty          out_o (chunk_out_t)
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
//  Each chunk scans the active node loads: they sit in one RAM whose single
//  read port is scanned one load per cycle, followed by an update step.
//  A row takes a task-load step, then a scan and update per chunk (up to MAX_CHUNKS).
//  Reset clears the loads at once through per-node valid bits.
//  Two-entry queues on the request and result sides let either side stall.
// ----------------------------------------------------------------------------
module least_loaded_chunk_assigner import llca_pkg::*; #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_CHUNKS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  row_in_t               in_i,
  output logic                  empty,
  input  logic                  pop,
  output chunk_out_t            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int NW = $clog2(MAX_NODES + 1);

  logic [4:0]    node_count_q;
  logic [15:0]   chunk_limit_q;
  task_t         tsk;
  logic          task_valid;
  logic          task_pop;
  logic [NW-1:0] n_act;
  chunk_out_t    res;
  logic          res_push;
  logic          res_full;
  logic [$bits(chunk_out_t)-1:0] out_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NODE_COUNT_RST;
      chunk_limit_q <= CHUNK_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_COUNT:  node_count_q  <= cfg_wdata_i[4:0];
        CFG_CHUNK_LIMIT: chunk_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  llca_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_i          (in_i),
    .node_count_i  (node_count_q),
    .chunk_limit_i (chunk_limit_q),
    .task_o        (tsk),
    .task_valid_o  (task_valid),
    .task_pop_i    (task_pop),
    .n_o           (n_act)
  );

  llca_back #(.MAX_NODES(MAX_NODES), .MAX_CHUNKS(MAX_CHUNKS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_act),
    .task_i       (tsk),
    .task_valid_i (task_valid),
    .task_pop_o   (task_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  llca_fifo #(.W($bits(chunk_out_t))) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign out_o = chunk_out_t'(out_raw);

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    task_pop |-> task_valid) else $error("task taken from an empty queue");

  a_load_covers_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res.new_load >= {16'd0, res.chunk_length}))
    else $error("new load below chunk length");
`endif

endmodule
